// File: src/ees_pkg.sv
// Shared types and constants for the I2C EEPROM transfer sequencer.
package ees_pkg;

    localparam int PAGE_BYTES = 16;
    localparam int PAGE_AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

    typedef enum logic [1:0] {
        FN_READ  = 2'd0,
        FN_WRITE = 2'd1,
        FN_STEP  = 2'd2,
        FN_NOP   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_SEND    = 3'd2,
        CMD_RX_ACK  = 3'd3,
        CMD_RX_NACK = 3'd4,
        CMD_STOP    = 3'd5
    } t_cmd;

    localparam logic [1:0] REG_SELECT_BASE = 2'd0;
    localparam logic [1:0] REG_WIDE_ADDR   = 2'd1;
    localparam logic [1:0] REG_MAX_ATTEMPT = 2'd2;

    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_REP_START   = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST    = 8'h38;
    localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
    localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

    localparam logic [2:0] HI_ADDR_MASK = 3'h7;

    // Classified request passed from the front part to the back part.
    typedef struct packed {
        logic       is_req;
        logic       is_write;
        logic [15:0] address;
        logic [7:0] length;
        logic [7:0] bus_status;
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
    } t_job;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_value;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       done_res;
        logic       failed;
        logic [7:0] byte_count;
        logic       last;
    } t_res;

endpackage

// File: src/ees_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
interface ees_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  length;
    logic [7:0]  bus_status;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
    modport source (output valid, func, address, length, bus_status, rx_byte, tx_byte,
                    input ready);
    modport sink (input valid, func, address, length, bus_status, rx_byte, tx_byte,
                  output ready);
endinterface

interface ees_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] tx_value;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       done_res;
    logic       failed;
    logic [7:0] byte_count;
    logic       last;
    modport source (output valid, command, tx_value, rx_valid, rx_data, done_res, failed,
                    byte_count, last, input ready);
    modport sink (input valid, command, tx_value, rx_valid, rx_data, done_res, failed,
                  byte_count, last, output ready);
endinterface

interface ees_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: src/i2c_eeprom_transfer_sequencer_unit.sv
// A request or bus status passes through the intake queue and then the phase machine's
// output register before its first result appears.
// One item per cycle while the output is not back-pressured; a page-boundary step gives two
// results and stalls the phase machine while the second drains, which the queue absorbs.
// A two-entry queue decouples intake from the phase machine.
// Reset is synchronous and active low; queue and result data registers are not reset.
module i2c_eeprom_transfer_sequencer_unit import ees_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ees_in_if.sink  in_ch,
    ees_cfg_if.sink cfg_ch,
    ees_out_if.source out_ch
);
    logic [7:0] r_sel_base, r_max_att;
    logic       r_wide;
    logic       w_valid, w_ready;
    t_job       w_job;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_base <= 8'd160;
            r_wide     <= 1'b0;
            r_max_att  <= 8'd200;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                REG_SELECT_BASE: r_sel_base <= cfg_ch.data;
                REG_WIDE_ADDR:   r_wide <= cfg_ch.data[0];
                REG_MAX_ATTEMPT: r_max_att <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    ees_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_valid(w_valid), .o_job(w_job), .i_ready(w_ready)
    );

    ees_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_job(w_job),
        .o_ready(w_ready), .i_sel_base(r_sel_base), .i_wide(r_wide),
        .i_max_att(r_max_att), .out_ch(out_ch)
    );
endmodule

// File: src/ees_front.sv
// Front part: accepts requests, drops no-op codes and queues jobs.
module ees_front import ees_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ees_in_if.sink    in_ch,
    output logic      o_valid,
    output t_job      o_job,
    input  logic      i_ready
);
    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_acc, w_keep, w_pop;
    t_job       w_job;

    assign in_ch.ready = (r_cnt != 2'd2);
    assign w_acc  = in_ch.valid && in_ch.ready;
    assign w_keep = w_acc && (in_ch.func != FN_NOP);
    assign w_pop  = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];

    always_comb begin
        w_job.is_req     = (in_ch.func == FN_READ) || (in_ch.func == FN_WRITE);
        w_job.is_write   = (in_ch.func == FN_WRITE);
        w_job.address    = in_ch.address;
        w_job.length     = in_ch.length;
        w_job.bus_status = in_ch.bus_status;
        w_job.rx_byte    = in_ch.rx_byte;
        w_job.tx_byte    = in_ch.tx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_keep) begin
                r_q[r_wp] <= w_job;
                r_wp <= ~r_wp;
            end
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_keep} - {1'b0, w_pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !w_keep) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_cnt != 2'd0)) else $error("pop from empty queue");
`endif
endmodule

// File: src/ees_back.sv
// Back part: phase machine that turns jobs into bus commands and results.
module ees_back import ees_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_job       i_job,
    output logic       o_ready,
    input  logic [7:0] i_sel_base,
    input  logic       i_wide,
    input  logic [7:0] i_max_att,
    ees_out_if.source  out_ch
);
    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_SLA_W, PH_ADDR_HI, PH_ADDR_LO,
        PH_RSTART, PH_SLA_R, PH_RX, PH_TX
    } t_phase;

    t_phase      r_ph, n_ph;
    logic        r_wr, n_wr;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_rem, n_rem, r_prem, n_prem, r_xfer, n_xfer, r_att, n_att;
    // Output slots: a primary and an optional second result.
    t_res        r_o0, n_o0, r_o1, n_o1;
    logic        r_v0, r_v1, n_v0, n_v1;
    logic        w_take, w_pop;
    logic        w_ign;
    t_res        w_r0, w_r1;
    logic        w_two;
    logic [7:0]  w_sel;
    logic [8:0]  w_room;
    logic [7:0]  w_plen;
    logic [7:0]  w_rem_d;
    logic [7:0]  w_st;

    // A result pair is taken only when the second slot is free and the first is free or draining now.
    assign w_pop   = out_ch.ready && r_v0;
    assign o_ready = !r_v1 && (!r_v0 || out_ch.ready);
    assign w_take  = i_valid && o_ready;
    assign w_st    = i_job.bus_status;

    function automatic t_res mk(input logic [2:0] c, input logic [7:0] tx,
                                input logic rv, input logic [7:0] rd,
                                input logic d, input logic f, input logic [7:0] bc);
        t_res r;
        r.command = c; r.tx_value = tx; r.rx_valid = rv; r.rx_data = rd;
        r.done_res = d; r.failed = f; r.byte_count = bc; r.last = 1'b0;
        return r;
    endfunction

    always_comb begin
        w_sel = i_sel_base;
        if (!i_wide) w_sel = i_sel_base | {4'd0, r_addr[10:8] & HI_ADDR_MASK, 1'b0};
    end

    always_comb begin
        logic [15:0] a;
        logic [7:0]  rem;
        a = i_job.is_req ? i_job.address : r_addr + 16'd1;
        rem = i_job.is_req ? i_job.length : r_rem - 8'd1;
        w_room = 9'(PAGE_BYTES) - {1'b0, 8'(a[PAGE_AW-1:0])};
        if (PAGE_BYTES == 1) w_room = 9'd1;
        w_plen = ({1'b0, rem} < w_room) ? rem : w_room[7:0];
        w_rem_d = r_rem - 8'd1;
    end

    always_comb begin
        n_ph = r_ph; n_wr = r_wr; n_addr = r_addr; n_rem = r_rem;
        n_prem = r_prem; n_xfer = r_xfer; n_att = r_att;
        w_ign = 1'b0; w_two = 1'b0;
        w_r0 = mk(CMD_NONE, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, r_xfer);
        w_r1 = w_r0;
        if (i_job.is_req) begin
            if (r_ph != PH_IDLE) w_ign = 1'b1;
            else begin
                n_wr = i_job.is_write; n_addr = i_job.address; n_rem = i_job.length;
                n_xfer = 8'd0;
                n_prem = i_job.is_write ? w_plen : 8'd0;
                if (i_max_att == 8'd0) begin
                    w_r0 = mk(CMD_NONE, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, 8'd0);
                    n_att = 8'd0;
                end else begin
                    n_att = 8'd1; n_ph = PH_START;
                    w_r0 = mk(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
                end
            end
        end else begin
            unique case (r_ph)
                PH_IDLE: w_ign = 1'b1;
                PH_START: begin
                    if (w_st == ST_START || w_st == ST_REP_START) begin
                        n_ph = PH_SLA_W;
                        w_r0 = mk(CMD_SEND, w_sel, 1'b0, 8'd0, 1'b0, 1'b0, r_xfer);
                    end else if (w_st == ST_ARB_LOST) begin
                        w_r0 = mk(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, r_xfer);
                    end else begin
                        n_ph = PH_IDLE;
                        w_r0 = mk(CMD_NONE, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, r_xfer);
                    end
                end
                PH_SLA_W: begin
                    if (w_st == ST_SLA_W_ACK) begin
                        n_ph = i_wide ? PH_ADDR_HI : PH_ADDR_LO;
                        w_r0 = mk(CMD_SEND, i_wide ? r_addr[15:8] : r_addr[7:0], 1'b0,
                                  8'd0, 1'b0, 1'b0, r_xfer);
                    end else if (w_st == ST_SLA_W_NACK) begin
                        if (r_att >= i_max_att) begin
                            n_ph = PH_IDLE;
                            w_r0 = mk(CMD_NONE, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, r_xfer);
                        end else begin
                            n_att = r_att + 8'd1; n_ph = PH_START;
                            w_r0 = mk(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, r_xfer);
                        end
                    end else if (w_st == ST_ARB_LOST) begin
                        n_ph = PH_START;
                        w_r0 = mk(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, r_xfer);
                    end else begin
                        n_ph = PH_IDLE;
                        w_r0 = mk(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, r_xfer);
                    end
                end
                PH_ADDR_HI, PH_ADDR_LO: begin
                    if (w_st == ST_DATA_W_ACK) begin
                        if (r_ph == PH_ADDR_HI) begin
                            n_ph = PH_ADDR_LO;
                            w_r0 = mk(CMD_SEND, r_addr[7:0], 1'b0, 8'd0, 1'b0, 1'b0, r_xfer);
                        end else if (!r_wr) begin
                            n_ph = PH_RSTART;
                            w_r0 = mk(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, r_xfer);
                        end else if (r_prem == 8'd0) begin
                            n_ph = PH_IDLE;
                            w_r0 = mk(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0, r_xfer);
                        end else begin
                            n_ph = PH_TX;
                            w_r0 = mk(CMD_SEND, i_job.tx_byte, 1'b0, 8'd0, 1'b0, 1'b0,
                                      r_xfer);
                        end
                    end else if (w_st == ST_DATA_W_NACK) begin
                        n_ph = PH_IDLE;
                        w_r0 = mk(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, r_wr, r_xfer);
                    end else if (w_st == ST_ARB_LOST) begin
                        n_ph = PH_START;
                        w_r0 = mk(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, r_xfer);
                    end else begin
                        n_ph = PH_IDLE;
                        w_r0 = mk(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, r_xfer);
                    end
                end
                PH_RSTART: begin
                    if (w_st == ST_START || w_st == ST_REP_START) begin
                        n_ph = PH_SLA_R;
                        w_r0 = mk(CMD_SEND, w_sel | 8'd1, 1'b0, 8'd0, 1'b0, 1'b0, r_xfer);
                    end else if (w_st == ST_ARB_LOST) begin
                        n_ph = PH_START;
                        w_r0 = mk(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, r_xfer);
                    end else begin
                        n_ph = PH_IDLE;
                        w_r0 = mk(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, r_xfer);
                    end
                end
                PH_SLA_R: begin
                    if (w_st == ST_SLA_R_ACK) begin
                        if (r_rem == 8'd0) begin
                            n_ph = PH_IDLE;
                            w_r0 = mk(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0, r_xfer);
                        end else begin
                            n_ph = PH_RX;
                            w_r0 = mk((r_rem > 8'd1) ? CMD_RX_ACK : CMD_RX_NACK, 8'd0, 1'b0,
                                      8'd0, 1'b0, 1'b0, r_xfer);
                        end
                    end else if (w_st == ST_SLA_R_NACK) begin
                        n_ph = PH_IDLE;
                        w_r0 = mk(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0, r_xfer);
                    end else if (w_st == ST_ARB_LOST) begin
                        n_ph = PH_START;
                        w_r0 = mk(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, r_xfer);
                    end else begin
                        n_ph = PH_IDLE;
                        w_r0 = mk(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, r_xfer);
                    end
                end
                PH_RX: begin
                    if (w_st == ST_DATA_R_ACK || w_st == ST_DATA_R_NACK) begin
                        n_xfer = r_xfer + 8'd1; n_rem = w_rem_d;
                        if (w_st == ST_DATA_R_NACK || w_rem_d == 8'd0) begin
                            n_ph = PH_IDLE;
                            w_r0 = mk(CMD_STOP, 8'd0, 1'b1, i_job.rx_byte, 1'b1, 1'b0,
                                      n_xfer);
                        end else begin
                            w_r0 = mk((w_rem_d > 8'd1) ? CMD_RX_ACK : CMD_RX_NACK, 8'd0,
                                      1'b1, i_job.rx_byte, 1'b0, 1'b0, n_xfer);
                        end
                    end else begin
                        n_ph = PH_IDLE;
                        w_r0 = mk(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, r_xfer);
                    end
                end
                PH_TX: begin
                    if (w_st != ST_DATA_W_ACK) begin
                        n_ph = PH_IDLE;
                        w_r0 = mk(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, r_xfer);
                    end else begin
                        n_xfer = r_xfer + 8'd1; n_rem = w_rem_d;
                        n_prem = r_prem - 8'd1; n_addr = r_addr + 16'd1;
                        if (n_prem != 8'd0) begin
                            w_r0 = mk(CMD_SEND, i_job.tx_byte, 1'b0, 8'd0, 1'b0, 1'b0,
                                      n_xfer);
                        end else if (w_rem_d == 8'd0) begin
                            n_ph = PH_IDLE;
                            w_r0 = mk(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0, n_xfer);
                        end else begin
                            // Page boundary: stop this page, then start the next one.
                            w_two = 1'b1;
                            w_r0 = mk(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, n_xfer);
                            n_prem = w_plen;
                            if (i_max_att == 8'd0) begin
                                n_att = 8'd0; n_ph = PH_IDLE;
                                w_r1 = mk(CMD_NONE, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, n_xfer);
                            end else begin
                                n_att = 8'd1; n_ph = PH_START;
                                w_r1 = mk(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, n_xfer);
                            end
                        end
                    end
                end
                default: n_ph = PH_IDLE;
            endcase
        end
        if (w_two) w_r1.last = 1'b1;
        else w_r0.last = 1'b1;
    end

    always_comb begin
        n_o0 = r_o0; n_o1 = r_o1; n_v0 = r_v0; n_v1 = r_v1;
        if (w_pop) begin
            n_o0 = r_o1; n_v0 = r_v1; n_v1 = 1'b0;
        end
        if (w_take && !w_ign) begin
            n_o0 = w_r0; n_v0 = 1'b1;
            n_o1 = w_r1; n_v1 = w_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE; r_wr <= 1'b0; r_addr <= 16'd0; r_rem <= 8'd0;
            r_prem <= 8'd0; r_xfer <= 8'd0; r_att <= 8'd0;
            r_v0 <= 1'b0; r_v1 <= 1'b0;
        end else begin
            if (w_take && !w_ign) begin
                r_ph <= n_ph; r_wr <= n_wr; r_addr <= n_addr; r_rem <= n_rem;
                r_prem <= n_prem; r_xfer <= n_xfer; r_att <= n_att;
            end
            r_v0 <= n_v0; r_v1 <= n_v1;
        end
        r_o0 <= n_o0; r_o1 <= n_o1;
    end

    assign out_ch.valid      = r_v0;
    assign out_ch.command    = r_o0.command;
    assign out_ch.tx_value   = r_o0.tx_value;
    assign out_ch.rx_valid   = r_o0.rx_valid;
    assign out_ch.rx_data    = r_o0.rx_data;
    assign out_ch.done_res   = r_o0.done_res;
    assign out_ch.failed     = r_o0.failed;
    assign out_ch.byte_count = r_o0.byte_count;
    assign out_ch.last       = r_o0.last;

`ifndef ASSERT_OFF
    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0) else $error("second slot valid without first");
    a_second_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_o1.last && !r_o0.last)) else $error("pair last marking wrong");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_ign && (w_two ? w_r1.done_res : w_r0.done_res)) |=> (r_ph == PH_IDLE))
        else $error("done without returning to idle");
`endif
endmodule
